// ===== hdl/cve_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the CIGAR variant extractor.
// No dependencies; every other file but cve_if imports this package.
package cve_pkg;

    localparam int OP_W    = 4;
    localparam int LEN_W   = 16;
    localparam int POS_W   = 32;
    localparam int KIND_W  = 2;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // CIGAR operation codes.
    localparam logic [OP_W-1:0] OP_M  = 4'd0;
    localparam logic [OP_W-1:0] OP_I  = 4'd1;
    localparam logic [OP_W-1:0] OP_D  = 4'd2;
    localparam logic [OP_W-1:0] OP_N  = 4'd3;
    localparam logic [OP_W-1:0] OP_S  = 4'd4;
    localparam logic [OP_W-1:0] OP_H  = 4'd5;
    localparam logic [OP_W-1:0] OP_P  = 4'd6;
    localparam logic [OP_W-1:0] OP_EQ = 4'd7;
    localparam logic [OP_W-1:0] OP_X  = 4'd8;

    // Variant kinds.
    localparam logic [KIND_W-1:0] KIND_INS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUB = 2'd2;

    typedef enum logic [2:0] {
        CLS_INS,
        CLS_DEL,
        CLS_SUB,
        CLS_ADV,
        CLS_SKIP,
        CLS_NONE
    } op_class_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FINS,
        ST_FDEL,
        ST_OP,
        ST_TINS,
        ST_TDEL
    } step_t;

    typedef struct packed {
        op_class_t         cls;
        logic [LEN_W-1:0]  len;
        logic              is_first;
        logic              is_final;
        logic [POS_W-1:0]  ref_start;
        logic [POS_W-1:0]  query_start;
        logic [POS_W-1:0]  genome_load;
    } item_t;

endpackage

// ===== hdl/cve_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operation beats and variant beats.
// Depends on nothing but the field widths written out here.
interface cve_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op_code;
    logic [15:0] op_len;
    logic        is_first;
    logic        is_final;
    logic [31:0] ref_start;
    logic [31:0] query_start;
    logic [31:0] genomic_start;

    modport source (output valid, op_code, op_len, is_first, is_final, ref_start,
                    query_start, genomic_start, input ready);
    modport sink (input valid, op_code, op_len, is_first, is_final, ref_start,
                  query_start, genomic_start, output ready);
endinterface

interface cve_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  variant_kind;
    logic [15:0] var_length;
    logic [31:0] ref_pos;
    logic [31:0] query_pos;
    logic [31:0] genome_pos;
    logic        last_of_run;

    modport source (output valid, variant_kind, var_length, ref_pos, query_pos,
                    genome_pos, last_of_run, input ready);
    modport sink (input valid, variant_kind, var_length, ref_pos, query_pos,
                  genome_pos, last_of_run, output ready);
endinterface

// ===== hdl/cve_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts operation beats and classifies them into queue entries.
// Depends on cve_pkg and cve_in_if.
module cve_front
(
    cve_in_if.sink          in_ch,
    output cve_pkg::item_t  item,
    output logic            push,
    input  logic            room
);
    import cve_pkg::*;

    op_class_t cls;

    always_comb
    begin
        case (in_ch.op_code)
            OP_I:    cls = CLS_INS;
            OP_D:    cls = CLS_DEL;
            OP_X:    cls = CLS_SUB;
            OP_S:    cls = CLS_SKIP;
            OP_M,
            OP_N,
            OP_H,
            OP_P,
            OP_EQ:   cls = CLS_ADV;
            default: cls = CLS_NONE;
        endcase
    end

    always_comb
    begin
        item.cls         = cls;
        item.len         = in_ch.op_len;
        item.is_first    = in_ch.is_first;
        item.is_final    = in_ch.is_final;
        item.ref_start   = in_ch.ref_start;
        item.query_start = in_ch.query_start;
        // One-based start becomes zero-based; a start of zero stays at zero.
        item.genome_load = (in_ch.genomic_start != '0) ?
                           in_ch.genomic_start - POS_W'(1) : '0;
    end

    assign in_ch.ready = room;
    assign push        = in_ch.valid & room;

endmodule

// ===== hdl/cve_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified operations between the front and back ends.
// Depends on cve_pkg.
module cve_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  cve_pkg::item_t  wr_item,
    input  logic            push,
    output logic            room,
    output cve_pkg::item_t  head,
    output logic            head_valid,
    input  logic            pop
);
    import cve_pkg::*;

    item_t             mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
    endfunction

    assign room       = (count_reg != Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hdl/cve_back.sv =====
`timescale 1ns / 1ps
// Back end: walks each queued operation through its steps, keeps the positions
// and pending gap totals, and drives the registered variant output. Uses cve_pkg.
module cve_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  cve_pkg::item_t  head,
    input  logic            head_valid,
    output logic            pop,
    cve_out_if.source       out_ch
);
    import cve_pkg::*;

    step_t              step_reg, step_next;
    step_t              act;
    logic [POS_W-1:0]   ref_reg, ref_next;
    logic [POS_W-1:0]   query_reg, query_next;
    logic [POS_W-1:0]   genome_reg, genome_next;
    logic [LEN_W-1:0]   pins_reg, pins_next;
    logic [LEN_W-1:0]   pdel_reg, pdel_next;
    logic               has_ins_reg, has_ins_next;
    logic               has_del_reg, has_del_next;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [POS_W-1:0]   out_ref_reg, out_query_reg, out_genome_reg;
    logic               out_last_reg;

    logic               flush_cls;
    logic               fins_ok, fdel_ok;
    logic               emits, fire, out_free;
    logic [KIND_W-1:0]  emit_kind;
    logic [LEN_W-1:0]   emit_len;
    logic               emit_last;

    assign flush_cls = (head.cls == CLS_SUB) || (head.cls == CLS_ADV)
                       || (head.cls == CLS_SKIP);
    assign fins_ok   = flush_cls && has_ins_reg;
    assign fdel_ok   = flush_cls && has_del_reg;
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Next state: pick the first step still to do, then move on or retire.
    always_comb
    begin
        case (step_reg)
            ST_LOAD: act = head.is_first ? ST_LOAD :
                           fins_ok ? ST_FINS : fdel_ok ? ST_FDEL : ST_OP;
            ST_FINS: act = fins_ok ? ST_FINS : fdel_ok ? ST_FDEL : ST_OP;
            ST_FDEL: act = fdel_ok ? ST_FDEL : ST_OP;
            ST_OP:   act = ST_OP;
            ST_TINS: act = has_ins_reg ? ST_TINS : ST_TDEL;
            ST_TDEL: act = ST_TDEL;
            default: act = ST_OP;
        endcase

        emits = (act == ST_FINS) || (act == ST_FDEL) || (act == ST_TINS)
                || (act == ST_TDEL) || ((act == ST_OP) && (head.cls == CLS_SUB));
        fire  = head_valid && (!emits || out_free);

        pop = 1'b0;
        case (act)
            ST_OP:   pop = fire && !(head.is_final && (has_ins_reg || has_del_reg
                           || (head.cls == CLS_INS) || (head.cls == CLS_DEL)));
            ST_TINS: pop = fire && !has_del_reg;
            ST_TDEL: pop = fire;
            default: pop = 1'b0;
        endcase

        step_next = step_reg;
        if (fire)
        begin
            if (pop)
            begin
                step_next = ST_LOAD;
            end
            else
            begin
                case (act)
                    ST_LOAD: step_next = ST_FINS;
                    ST_FINS: step_next = ST_FDEL;
                    ST_FDEL: step_next = ST_OP;
                    ST_OP:   step_next = ST_TINS;
                    ST_TINS: step_next = ST_TDEL;
                    default: step_next = ST_LOAD;
                endcase
            end
        end
    end

    // Outputs: what the chosen step reports.
    always_comb
    begin
        case (act)
            ST_FINS:
            begin
                emit_kind = KIND_INS;
                emit_len  = pins_reg;
                emit_last = !(has_del_reg || head.cls == CLS_SUB);
            end
            ST_FDEL:
            begin
                emit_kind = KIND_DEL;
                emit_len  = pdel_reg;
                emit_last = (head.cls != CLS_SUB);
            end
            ST_TINS:
            begin
                emit_kind = KIND_INS;
                emit_len  = pins_reg;
                emit_last = !has_del_reg;
            end
            ST_TDEL:
            begin
                emit_kind = KIND_DEL;
                emit_len  = pdel_reg;
                emit_last = 1'b1;
            end
            default:
            begin
                emit_kind = KIND_SUB;
                emit_len  = head.len;
                emit_last = 1'b1;
            end
        endcase
    end

    // Position and pending-gap datapath.
    always_comb
    begin
        ref_next     = ref_reg;
        query_next   = query_reg;
        genome_next  = genome_reg;
        pins_next    = pins_reg;
        pdel_next    = pdel_reg;
        has_ins_next = has_ins_reg;
        has_del_next = has_del_reg;
        if (fire)
        begin
            case (act)
                ST_LOAD:
                begin
                    ref_next     = head.ref_start;
                    query_next   = head.query_start;
                    genome_next  = head.genome_load;
                    pins_next    = '0;
                    pdel_next    = '0;
                    has_ins_next = 1'b0;
                    has_del_next = 1'b0;
                end
                ST_FINS,
                ST_TINS:
                begin
                    query_next   = query_reg + POS_W'(pins_reg);
                    pins_next    = '0;
                    has_ins_next = 1'b0;
                end
                ST_FDEL,
                ST_TDEL:
                begin
                    ref_next     = ref_reg + POS_W'(pdel_reg);
                    genome_next  = genome_reg + POS_W'(pdel_reg);
                    pdel_next    = '0;
                    has_del_next = 1'b0;
                end
                default:
                begin
                    case (head.cls)
                        CLS_INS:
                        begin
                            pins_next    = pins_reg + head.len;
                            has_ins_next = 1'b1;
                        end
                        CLS_DEL:
                        begin
                            pdel_next    = pdel_reg + head.len;
                            has_del_next = 1'b1;
                        end
                        CLS_SUB,
                        CLS_ADV:
                        begin
                            ref_next    = ref_reg + POS_W'(head.len);
                            query_next  = query_reg + POS_W'(head.len);
                            genome_next = genome_reg + POS_W'(head.len);
                        end
                        default:
                        begin
                            ref_next = ref_reg;
                        end
                    endcase
                end
            endcase
        end
        out_valid_next = out_free ? (fire && emits) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_LOAD;
            ref_reg       <= '0;
            query_reg     <= '0;
            genome_reg    <= '0;
            pins_reg      <= '0;
            pdel_reg      <= '0;
            has_ins_reg   <= 1'b0;
            has_del_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            ref_reg       <= ref_next;
            query_reg     <= query_next;
            genome_reg    <= genome_next;
            pins_reg      <= pins_next;
            pdel_reg      <= pdel_next;
            has_ins_reg   <= has_ins_next;
            has_del_reg   <= has_del_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emits)
        begin
            out_kind_reg   <= emit_kind;
            out_len_reg    <= emit_len;
            out_ref_reg    <= ref_reg;
            out_query_reg  <= query_reg;
            out_genome_reg <= genome_reg;
            out_last_reg   <= emit_last;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.variant_kind = out_kind_reg;
    assign out_ch.var_length   = out_len_reg;
    assign out_ch.ref_pos      = out_ref_reg;
    assign out_ch.query_pos    = out_query_reg;
    assign out_ch.genome_pos   = out_genome_reg;
    assign out_ch.last_of_run  = out_last_reg;

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && act == ST_LOAD) |=> (!has_ins_reg && !has_del_reg))
        else $error("pending gaps survive a start-position load");

    a_ins_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (act == ST_FINS || act == ST_TINS)) |=> !has_ins_reg)
        else $error("insertion still pending after its flush");

    a_tdel_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_TDEL) |-> has_del_reg)
        else $error("trailing deletion step without a pending deletion");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emits) |=> out_valid_reg)
        else $error("emitted variant did not reach the output register");

endmodule

// ===== hdl/cigar_variant_extractor_core.sv =====
`timescale 1ns / 1ps
// Top level of the CIGAR variant extractor: front end, queue and back end.
// Depends on cve_pkg, cve_if, cve_front, cve_queue and cve_back.
//
// Takes one CIGAR operation per input beat and reports insertions, deletions
// and substitutions as output beats. The front end decodes each operation and
// works out the zero-based genomic start, then parks it in a two-entry queue,
// so new operations are taken while the back end is still busy or the output
// is stalled. The back end owns the reference, query and genomic positions and
// the pending gap totals, and handles one queued operation as a short series
// of steps: loading the start positions on a first operation, flushing a
// pending insertion, flushing a pending deletion, the operation itself (a
// substitution is reported in this step), and the trailing insertion and
// deletion flushes of a final operation. Steps that have nothing to do are
// skipped. A load discards whatever was pending, so it leaves at most one
// gap to flush afterwards. One result at most leaves per cycle.
// The output is registered, and the back end keeps going while a result waits
// as long as the consumer takes it.
// last_of_run marks the last variant that a given operation caused.
module cigar_variant_extractor_core
(
    input  logic        clk,
    input  logic        rst_n,
    cve_in_if.sink      in_ch,
    cve_out_if.source   out_ch
);
    import cve_pkg::*;

    item_t  front_item;
    item_t  head;
    logic   push;
    logic   room;
    logic   head_valid;
    logic   pop;

    // Decode and classify operation beats.
    cve_front u_front
    (
        .in_ch (in_ch),
        .item  (front_item),
        .push  (push),
        .room  (room)
    );

    // Decouples acceptance from execution.
    cve_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_item    (front_item),
        .push       (push),
        .room       (room),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // Position tracking, gap merging and result generation.
    cve_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

// ===== tb/sv/cve_variant_check.sv =====
`timescale 1ns / 1ps
// Watches the operation and variant channels of the CIGAR variant extractor,
// predicts the variants from each operation beat and compares every result beat.
// Depends on cve_pkg and cve_if.
module cve_variant_check
(
    input  logic clk,
    input  logic rst_n,
    cve_in_if    in_ch,
    cve_out_if   out_ch,
    output int   fail_count,
    output int   outstanding
);
    import cve_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [POS_W-1:0]  ref_pos;
        logic [POS_W-1:0]  query_pos;
        logic [POS_W-1:0]  genome_pos;
        logic              last;
    } variant_t;

    // Walk positions and open gap totals, kept in step with the block.
    logic [POS_W-1:0] ref_at;
    logic [POS_W-1:0] qry_at;
    logic [POS_W-1:0] gen_at;
    logic [LEN_W-1:0] ins_sum;
    logic [LEN_W-1:0] del_sum;
    logic             ins_open;
    logic             del_open;

    variant_t variants_due[$];
    int       errors = 0;

    assign fail_count = errors;

    task automatic emit_variant(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                                inout int made);
        variant_t v;
        v.kind       = kind;
        v.len        = len;
        v.ref_pos    = ref_at;
        v.query_pos  = qry_at;
        v.genome_pos = gen_at;
        v.last       = 1'b0;
        variants_due = {variants_due, v};
        made++;
    endtask

    task automatic close_gaps(inout int made);
        if (ins_open)
        begin
            emit_variant(KIND_INS, ins_sum, made);
            qry_at = qry_at + POS_W'(ins_sum);
        end
        if (del_open)
        begin
            emit_variant(KIND_DEL, del_sum, made);
            ref_at = ref_at + POS_W'(del_sum);
            gen_at = gen_at + POS_W'(del_sum);
        end
        ins_open = 1'b0;
        del_open = 1'b0;
        ins_sum  = '0;
        del_sum  = '0;
    endtask

    task automatic predict_variants(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                                    input logic head, input logic tail,
                                    input logic [POS_W-1:0] rs, input logic [POS_W-1:0] qs,
                                    input logic [POS_W-1:0] gs);
        int made;
        made = 0;
        if (head)
        begin
            ref_at   = rs;
            qry_at   = qs;
            gen_at   = (gs != '0) ? gs - POS_W'(1) : '0;
            ins_open = 1'b0;
            del_open = 1'b0;
            ins_sum  = '0;
            del_sum  = '0;
        end
        if (op == OP_I)
        begin
            ins_sum  = ins_sum + len;
            ins_open = 1'b1;
        end
        else if (op == OP_D)
        begin
            del_sum  = del_sum + len;
            del_open = 1'b1;
        end
        else if (op <= OP_X)
        begin
            close_gaps(made);
            if (op == OP_X)
                emit_variant(KIND_SUB, len, made);
            if (op != OP_S)
            begin
                ref_at = ref_at + POS_W'(len);
                qry_at = qry_at + POS_W'(len);
                gen_at = gen_at + POS_W'(len);
            end
        end
        if (tail)
            close_gaps(made);
        if (made > 0)
            variants_due[variants_due.size() - 1].last = 1'b1;
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    task automatic compare_variant();
        variant_t want;
        variant_t got;
        got.kind       = out_ch.variant_kind;
        got.len        = out_ch.var_length;
        got.ref_pos    = out_ch.ref_pos;
        got.query_pos  = out_ch.query_pos;
        got.genome_pos = out_ch.genome_pos;
        got.last       = out_ch.last_of_run;
        if (variants_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected variant beat: expected none, actual %h", $time, got);
        end
        else
        begin
            want = variants_due.pop_front();
            compare_field("variant_kind", 32'(want.kind), 32'(got.kind));
            compare_field("var_length", 32'(want.len), 32'(got.len));
            compare_field("ref_pos", want.ref_pos, got.ref_pos);
            compare_field("query_pos", want.query_pos, got.query_pos);
            compare_field("genome_pos", want.genome_pos, got.genome_pos);
            compare_field("last_of_run", 32'(want.last), 32'(got.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_at      = '0;
            qry_at      = '0;
            gen_at      = '0;
            ins_sum     = '0;
            del_sum     = '0;
            ins_open    = 1'b0;
            del_open    = 1'b0;
            outstanding <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_variants(in_ch.op_code, in_ch.op_len, in_ch.is_first, in_ch.is_final,
                                 in_ch.ref_start, in_ch.query_start, in_ch.genomic_start);
            if (out_ch.valid && out_ch.ready)
                compare_variant();
            outstanding <= variants_due.size();
        end
    end

endmodule

// ===== tb/sv/cigar_variant_extractor_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the CIGAR variant extractor bench: clock, reset, operation stimulus,
// result consumer, watchdog and verdict. Depends on cve_pkg, cve_if,
// cigar_variant_extractor_core and cve_variant_check.
module cigar_variant_extractor_core_tb;

    import cve_pkg::*;

    // Cycles without a single beat on either channel before the run is abandoned.
    // The longest honest quiet stretch is the consumer hold below plus the trip
    // through the queue and the output register, so this is many times over.
    localparam int IDLE_LIMIT  = 2000;
    // Length of the deliberate consumer stall that fills the block's queue.
    localparam int HOLD_CYCLES = 120;
    // Cycles allowed after the last expected variant for stray beats to show up.
    localparam int TAIL_CYCLES = 20;

    // Operation codes the block must ignore, at both ends of the unused range.
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_X + OP_W'(1);
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   idle_cycles = 0;

    // quiet switches off the random idling on both sides; hold_req asks the
    // consumer for one long stall.
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    cve_in_if  in_ch ();
    cve_out_if out_ch ();

    cigar_variant_extractor_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    cve_variant_check u_variant_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // The watchdog only counts cycles in which neither channel moves a beat, so
    // a long but healthy run never trips it.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result consumer. Before each beat it stalls for a random number of cycles,
    // none while the bench runs quiet, and once for a long stretch on request.
    // ready then stays high until a beat has actually been taken.
    initial
    begin : variant_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // Offers one operation beat and returns at the edge that accepts it. When no
    // gap is drawn, valid simply stays high and only the payload changes, so the
    // next beat follows back to back.
    task automatic drive_op(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                            input logic head, input logic tail,
                            input logic [POS_W-1:0] rs, input logic [POS_W-1:0] qs,
                            input logic [POS_W-1:0] gs);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op_code       <= op;
        in_ch.op_len        <= len;
        in_ch.is_first      <= head;
        in_ch.is_final      <= tail;
        in_ch.ref_start     <= rs;
        in_ch.query_start   <= qs;
        in_ch.genomic_start <= gs;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Withdraws the offer and waits until every predicted variant has been seen.
    // The first edge lets the checker account for the beat just accepted.
    task automatic drain_variants();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // Gaps and substitutions are favoured, since they are what produce variants
    // and exercise the merging; the other operations share the rest.
    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return OP_I;
        if (r < 50)
            return OP_D;
        if (r < 65)
            return OP_X;
        if (r < 78)
            return OP_M;
        case ($urandom_range(0, 4))
            0: return OP_N;
            1: return OP_S;
            2: return OP_H;
            3: return OP_P;
            default: return OP_EQ;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_spare_op();
        logic [OP_W-1:0] v;
        v = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        return v;
    endfunction

    // Mostly short lengths so positions stay readable, with zero, the maximum
    // and full-width values mixed in so that the 16-bit totals wrap.
    function automatic logic [LEN_W-1:0] pick_len();
        logic [LEN_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2, 3: v = LEN_W'($urandom);
            default: v = LEN_W'($urandom_range(1, 40));
        endcase
        return v;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Genomic starts of zero and one both end up at position zero.
    function automatic logic [POS_W-1:0] pick_gstart();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random traffic. Nine times in ten a whole alignment of one to eight
    // operations goes out, first and final beats marked; otherwise a single
    // stray beat with random flags, often an unused code. A stray beat with an
    // unused code and neither flag does nothing and is not counted.
    task automatic send_alignments(input int target);
        int              sent;
        int              span;
        logic [OP_W-1:0] op;
        logic            head;
        logic            tail;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                op   = ($urandom_range(0, 1) != 0) ? pick_spare_op() : pick_op();
                head = 1'($urandom_range(0, 1));
                tail = 1'($urandom_range(0, 1));
                drive_op(op, pick_len(), head, tail, pick_pos(), pick_pos(), pick_gstart());
                if (op <= OP_X || head || tail)
                    sent++;
            end
            else
            begin
                span = $urandom_range(1, 8);
                for (int k = 0; k < span; k++)
                begin
                    drive_op(pick_op(), pick_len(), k == 0, k == span - 1,
                             pick_pos(), pick_pos(), pick_gstart());
                    sent++;
                end
            end
        end
    endtask

    // Hand-picked alignments covering every operation, the merging of a gap run,
    // the zero-length gap flush, three variants from one beat, wrapping totals
    // and positions, the trailing flush, the discard on a first beat and the
    // unused codes. Start fields on beats that are not first carry junk, which
    // the block must ignore.
    task automatic directed_ops();
        // Genomic start of zero loads position zero; the M advances nothing.
        drive_op(OP_M, 16'd0, 1'b1, 1'b0, '0, '0, '0);
        // Insertions 5 and 2 and a deletion of 3 form one run, flushed by M.
        drive_op(OP_I, 16'd5, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_D, 16'd3, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_I, 16'd2, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_M, 16'd10, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_X, 16'd1, 1'b0, 1'b0, '1, '1, '1);
        // Soft clip does nothing, the rest advance all three positions.
        drive_op(OP_S, 16'd4, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_H, 16'd2, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_P, 16'd1, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_N, 16'd100, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_EQ, 16'd7, 1'b0, 1'b0, '1, '1, '1);
        // Zero-length gaps are still reported, then the substitution: three
        // variants from the one beat.
        drive_op(OP_I, 16'd0, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_D, 16'd0, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_X, '1, 1'b0, 1'b0, '1, '1, '1);
        // The deletion total wraps to zero; the final insertion flushes both.
        drive_op(OP_D, '1, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_D, 16'd1, 1'b0, 1'b0, '1, '1, '1);
        drive_op(OP_I, '1, 1'b0, 1'b1, '1, '1, '1);
        // One-beat alignment at the top of the position range, which wraps.
        drive_op(OP_X, '1, 1'b1, 1'b1, '1, '1, '1);
        // An unused code still loads the starts; genomic start one gives zero.
        drive_op(OP_SPARE_HI, 16'd9, 1'b1, 1'b0, 32'h1234_5678, 32'h0000_0100, 32'd1);
        drive_op(OP_I, 16'd4, 1'b0, 1'b0, '0, '0, '0);
        // An unused code marked final still flushes the pending insertion.
        drive_op(OP_SPARE_LO, 16'd3, 1'b0, 1'b1, '0, '0, '0);
        // A first beat throws away the insertion left open before it.
        drive_op(OP_I, 16'd3, 1'b0, 1'b0, '0, '0, '0);
        drive_op(OP_D, 16'd2, 1'b1, 1'b1, 32'h00AB_CDEF, 32'h8000_0000, 32'h0000_0010);
        drive_op(OP_I, 16'd1, 1'b1, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
        // First and final together with nothing to report.
        drive_op(OP_M, 16'd0, 1'b1, 1'b1, '0, '0, '0);
    endtask

    initial
    begin : stimulus
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.op_code       <= OP_M;
        in_ch.op_len        <= '0;
        in_ch.is_first      <= 1'b0;
        in_ch.is_final      <= 1'b0;
        in_ch.ref_start     <= '0;
        in_ch.query_start   <= '0;
        in_ch.genomic_start <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_ops();
        send_alignments(150);

        // The consumer stops for a long stretch while beats keep coming with no
        // gaps, so the queue fills and the block has to push back on its input.
        quiet    = 1'b1;
        hold_req = 1'b1;
        send_alignments(40);
        quiet    = 1'b0;

        // The producer waits for the block to empty completely, then resumes.
        drain_variants();
        send_alignments(130);

        // A stretch with no idling on either side.
        quiet = 1'b1;
        send_alignments(60);
        quiet = 1'b0;
        send_alignments(70);

        drain_variants();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
